// ===== hdl/aes_pkg.sv =====
// Shared constants, types and GF(2^8) helpers for the AES block engine.
package aes_pkg;

  localparam int unsigned RoundKeyWords = 60;
  localparam int unsigned RkAddrW       = $clog2(RoundKeyWords);
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 64;

  localparam logic [CfgIdxW-1:0] RegMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey1 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey2 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKey3 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIvHi = 3'd5;
  localparam logic [CfgIdxW-1:0] RegIvLo = 3'd6;

  typedef logic [7:0] byte_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Forward column mix on one 32-bit column, row 0 in the top byte.
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    byte_t a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // Inverse mix: premultiply by {05,00,04,00} then apply the forward mix.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    byte_t a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

endpackage

// ===== hdl/aes_stream_if.sv =====
// Valid/ready channel carrying one AES block item.
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic        restart_chain;

  modport source (output valid, block_hi, block_lo, restart_chain, input ready);
  modport sink (input valid, block_hi, block_lo, restart_chain, output ready);
endinterface

// ===== hdl/aes_result_if.sv =====
// Valid/ready channel carrying one AES result item.
interface aes_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_hi;
  logic [63:0] out_lo;

  modport source (output valid, out_hi, out_lo, input ready);
  modport sink (input valid, out_hi, out_lo, output ready);
endinterface

// ===== hdl/aes_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/aes_block_cipher_ecb_cbc.sv =====
// AES-128/192/256 block engine with ECB and CBC chaining.
//
// Blocks arrive on in_if (block_hi, block_lo, restart_chain) and leave on
// out_if (out_hi, out_lo), both valid/ready channels; an item moves when
// valid and ready are high at a rising clock edge. Configuration is written
// through cfg_we_i/cfg_idx_i/cfg_data_i while the engine is idle: index 0 is
// the mode, 1 to 4 the key words, 5 and 6 the IV.
// The engine handles one block at a time and is not ready while busy. A round
// reads one round-key word per cycle from the key RAM: the read ahead, then
// the four column words. A new item is taken only after the result of the
// current one has been handed to the output register. On the first block
// after a mode or key write the schedule is expanded first: each key word is
// copied in, then each derived word is built from an address step and a
// registered read.
// The result sits in an output register until taken, and the next item may be
// taken meanwhile; if the register is still full when that item finishes, the
// engine waits, and it takes no further item until the receiver drains it.
// Reset clears the control and config registers, the chain value and the
// schedule-valid flag, not data registers or key RAM (expanded before use).
module aes_block_cipher_ecb_cbc (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [aes_pkg::CfgDataW-1:0]   cfg_data_i,
  aes_stream_if.sink                     in_if,
  aes_result_if.source                   out_if
);
  import aes_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StExpand, StLoad, StRound, StDone
  } state_e;

  state_e       state_q;
  logic [3:0]   mode_q;
  logic [63:0]  key_q [4];
  logic [63:0]  iv_q [2];
  logic [127:0] chain_q;
  logic         keys_ready_q;
  logic [127:0] st_q;
  logic [127:0] blk_q;
  logic [127:0] acc_q;
  logic [RkAddrW-1:0] kidx_q;
  logic [3:0]   round_q;
  logic [2:0]   col_q;
  logic [31:0]  prev_q;
  logic [7:0]   rc_q;
  logic [2:0]   kc_q;
  logic         rd_pend_q;
  logic         out_valid_q;
  logic [127:0] out_q;

  logic [3:0] nk;
  logic [3:0] nr;
  logic       dec, cbc;
  assign nk  = (mode_q[1:0] == 2'd0) ? 4'd4 : (mode_q[1:0] == 2'd1) ? 4'd6 : 4'd8;
  assign nr  = nk + 4'd6;
  assign dec = mode_q[2];
  assign cbc = mode_q[3];

  // Key RAM.
  logic               ram_we;
  logic [RkAddrW-1:0] ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;

  aes_ram #(.Width(32), .Depth(RoundKeyWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Expansion: word i needs w[i-1] (prev_q) and w[i-nk] read from RAM.
  logic [31:0] exp_t, exp_w;
  logic [31:0] init_w;
  logic [2:0]  kw_idx;
  always_comb begin
    kw_idx = kidx_q[2:0];
    init_w = kw_idx[0] ? key_q[kw_idx[2:1]][31:0] : key_q[kw_idx[2:1]][63:32];
    exp_t  = prev_q;
    if (kc_q == 3'd0) begin
      exp_t = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rc_q, 24'h0};
    end else if (nk == 4'd8 && kc_q == 3'd4) begin
      exp_t = sub_word(prev_q);
    end
    exp_w = ram_rdata ^ exp_t;
  end

  // Key word index for the round being built, column col_q.
  logic [5:0] rk_base;
  assign rk_base = {round_q, 2'b00};

  // Round datapath on the whole state; one key word per column is XORed.
  logic [127:0] sb_sr, mixed;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) begin
          sb_sr[127 - 8*(((c + r) % 4)*4 + r) -: 8] = INV_SBOX[st_q[127 - 8*(c*4 + r) -: 8]];
        end else begin
          sb_sr[127 - 8*(c*4 + r) -: 8] = SBOX[st_q[127 - 8*(((c + r) % 4)*4 + r) -: 8]];
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32*c -: 32] = mix_col(sb_sr[127 - 32*c -: 32]);
    end
  end

  // Column words of the encrypt-side round input and decrypt-side pre-mix.
  logic        first_rnd, last_rnd;
  logic [31:0] col_in, col_key, col_out;
  logic [1:0]  ci;
  always_comb begin
    ci        = col_q[1:0] - 2'd1;
    first_rnd = (round_q == (dec ? nr : 4'd0));
    last_rnd  = (round_q == (dec ? 4'd0 : nr));
    col_key   = ram_rdata;
    if (first_rnd) begin
      col_in = st_q[127 - 32*ci -: 32];
    end else if (dec || last_rnd) begin
      col_in = sb_sr[127 - 32*ci -: 32];
    end else begin
      col_in = mixed[127 - 32*ci -: 32];
    end
    col_out = col_in ^ col_key;
    if (dec && !first_rnd && !last_rnd) begin
      col_out = inv_mix_col(col_out);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = kidx_q;
    ram_wdata = init_w;
    ram_raddr = rk_base + {4'd0, col_q[1:0]};
    if (state_q == StExpand) begin
      if (kidx_q < RkAddrW'(nk)) begin
        ram_we    = 1'b1;
        ram_wdata = init_w;
        ram_raddr = '0;
      end else begin
        ram_we    = rd_pend_q;
        ram_wdata = exp_w;
        ram_raddr = kidx_q - RkAddrW'(nk);
      end
    end
  end

  logic [5:0] total_w;
  assign total_w = {nk, 2'b00} + 6'd28;

  logic [127:0] in_blk;
  assign in_blk = {in_if.block_hi, in_if.block_lo};

  assign in_if.ready  = (state_q == StIdle);
  assign out_if.valid = out_valid_q;
  assign out_if.out_hi = out_q[127:64];
  assign out_if.out_lo = out_q[63:0];

  logic [127:0] chain_use;
  logic [127:0] fin;
  assign chain_use = in_if.restart_chain ? {iv_q[0], iv_q[1]} : chain_q;
  assign fin       = {acc_q[95:0], col_out};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      mode_q       <= '0;
      key_q        <= '{default: '0};
      iv_q         <= '{default: '0};
      chain_q      <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      kidx_q       <= '0;
      round_q      <= '0;
      col_q        <= '0;
      rd_pend_q    <= 1'b0;
      kc_q         <= '0;
      rc_q         <= 8'h01;
    end else begin
      if (out_if.valid && out_if.ready && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMode: begin mode_q <= cfg_data_i[3:0]; keys_ready_q <= 1'b0; end
          RegKey0, RegKey1, RegKey2, RegKey3: begin
            key_q[2'(cfg_idx_i - RegKey0)] <= cfg_data_i;
            keys_ready_q <= 1'b0;
          end
          RegIvHi: iv_q[0] <= cfg_data_i;
          RegIvLo: iv_q[1] <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_if.valid && in_if.ready) begin
            chain_q   <= chain_use;
            blk_q     <= in_blk;
            st_q      <= (cbc && !dec) ? (in_blk ^ chain_use) : in_blk;
            kidx_q    <= '0;
            kc_q      <= '0;
            rc_q      <= 8'h01;
            rd_pend_q <= 1'b0;
            state_q   <= keys_ready_q ? StLoad : StExpand;
          end
        end
        StExpand: begin
          // Each generated word issues its address, then uses the registered read.
          if (kidx_q < RkAddrW'(nk)) begin
            prev_q <= init_w;
            kidx_q <= kidx_q + RkAddrW'(1);
          end else if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
            prev_q    <= exp_w;
            if (kc_q == 3'd0) begin
              rc_q <= xtime(rc_q);
            end
            kc_q   <= (kc_q == 3'(nk - 4'd1)) ? 3'd0 : kc_q + 3'd1;
            kidx_q <= kidx_q + RkAddrW'(1);
            if (kidx_q + RkAddrW'(1) == total_w) begin
              keys_ready_q <= 1'b1;
              state_q      <= StLoad;
            end
          end
          if (kidx_q == RkAddrW'(nk) - RkAddrW'(1)) begin
            kc_q <= '0;
          end
        end
        StLoad: begin
          round_q <= dec ? nr : 4'd0;
          col_q   <= '0;
          state_q <= StRound;
        end
        StRound: begin
          // col 0 issues the read of key word 0; cols 1..4 consume words.
          if (col_q != 3'd0) begin
            acc_q <= {acc_q[95:0], col_out};
          end
          if (col_q == 3'd4) begin
            col_q <= '0;
            st_q  <= fin;
            if (last_rnd) begin
              state_q <= StDone;
            end else begin
              round_q <= dec ? round_q - 4'd1 : round_q + 4'd1;
            end
          end else begin
            col_q <= col_q + 3'd1;
          end
        end
        StDone: begin
          // Wait here while the previous result still sits in the output register.
          if (!out_valid_q || out_if.ready) begin
            if (cbc && !dec) begin
              out_q   <= st_q;
              chain_q <= st_q;
            end else if (cbc) begin
              out_q   <= st_q ^ chain_q;
              chain_q <= blk_q;
            end else begin
              out_q <= st_q;
            end
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Round key column 0 is read in the cycle before it is used; the address follows col_q.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> (col_q <= 3'd4))
    else $error("column counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> keys_ready_q)
    else $error("cipher started without an expanded schedule");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result raised outside the final step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_if.ready)
    else $error("input taken while busy");
endmodule
